// ===== rtl/core/hrhp_pkg.sv =====
// Package: shared types, constants and keyword tables for the request parser.
`default_nettype none
package hrhp_pkg;

  localparam int unsigned BufferBytes = 2048;
  localparam int unsigned CountW = $clog2(BufferBytes) + 1;

  localparam logic [1:0] VerdictOk       = 2'd0;
  localparam logic [1:0] VerdictBad      = 2'd1;
  localparam logic [1:0] VerdictOverflow = 2'd2;

  typedef enum logic [1:0] {
    PhaseReqLine = 2'd0,
    PhaseHeader  = 2'd1,
    PhaseBody    = 2'd2
  } phase_e;

  // Request line steps.
  localparam logic [3:0] StepMethod     = 4'd0;
  localparam logic [3:0] StepTargetGap  = 4'd1;
  localparam logic [3:0] StepTarget     = 4'd2;
  localparam logic [3:0] StepVersionGap = 4'd3;
  localparam logic [3:0] StepVersion    = 4'd4;

  // Header line steps.
  localparam logic [3:0] StepName     = 4'd0;
  localparam logic [3:0] StepValueGap = 4'd1;
  localparam logic [3:0] StepValue    = 4'd2;
  localparam logic [3:0] StepSkip     = 4'd3;

  localparam logic [7:0] ChCr    = 8'h0d;
  localparam logic [7:0] ChLf    = 8'h0a;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChSlash = 8'h2f;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;

  localparam int unsigned WGet = 0;
  localparam int unsigned WHttp = 2;
  localparam int unsigned WHdr = 4;
  localparam int unsigned WVersion = 7;
  localparam int unsigned WKeepAlive = 8;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       new_connection;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  verdict;
    logic        method;
    logic        keep_alive;
    logic [15:0] content_len;
    logic [10:0] url_offset;
    logic [11:0] url_length;
    logic        url_is_root;
    logic [10:0] host_offset;
    logic [11:0] host_length;
    logic [10:0] body_offset;
  } out_word_t;

  // Classified byte handed from front to back.
  typedef struct packed {
    logic [7:0]        data_byte;
    logic              new_connection;
    logic              is_ws;
    logic              is_digit;
    logic [7:0]        lower;
  } cls_word_t;

  function automatic logic [4:0] word_len(input logic [3:0] w);
    case (w)
      4'd0: word_len = 5'd3;
      4'd1: word_len = 5'd4;
      4'd2: word_len = 5'd7;
      4'd3: word_len = 5'd8;
      4'd4: word_len = 5'd11;
      4'd5: word_len = 5'd15;
      4'd6: word_len = 5'd5;
      4'd7: word_len = 5'd8;
      4'd8: word_len = 5'd10;
      default: word_len = 5'd0;
    endcase
  endfunction

  function automatic logic [7:0] word_char(input logic [3:0] w, input logic [4:0] i);
    logic [15:0][7:0] s;
    s = '0;
    case (w)
      4'd0: s[2:0] = {"t", "e", "g"};
      4'd1: s[3:0] = {"t", "s", "o", "p"};
      4'd2: s[6:0] = {"/", "/", ":", "p", "t", "t", "h"};
      4'd3: s[7:0] = {"/", "/", ":", "s", "p", "t", "t", "h"};
      4'd4: s[10:0] = {":", "n", "o", "i", "t", "c", "e", "n", "n", "o", "c"};
      4'd5: s[14:0] = {":", "h", "t", "g", "n", "e", "l", "-", "t", "n", "e", "t", "n", "o",
                       "c"};
      4'd6: s[4:0] = {":", "t", "s", "o", "h"};
      4'd7: s[7:0] = {"1", ".", "1", "/", "p", "t", "t", "h"};
      4'd8: s[9:0] = {"e", "v", "i", "l", "a", "-", "p", "e", "e", "k"};
      default: s = '0;
    endcase
    word_char = i[4] ? 8'h00 : s[i[3:0]];
  endfunction

  function automatic logic char_hit(input logic [3:0] w, input logic [4:0] i,
                                    input logic [7:0] lc);
    char_hit = (i < word_len(w)) && (lc == word_char(w, i));
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/hrhp_front.sv =====
// Front end: accept request bytes, classify them, push into a small queue.
`default_nettype none
module hrhp_front (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire hrhp_pkg::in_word_t  in_word_i,
  output logic                     q_valid_o,
  input  wire logic                q_pop_i,
  output hrhp_pkg::cls_word_t      q_word_o
);
  hrhp_pkg::cls_word_t mem_q [4];
  logic [1:0] wr_q, wr_d, rd_q, rd_d;
  logic [2:0] cnt_q, cnt_d;
  hrhp_pkg::cls_word_t cls;
  logic push, pop;

  always_comb begin
    cls.data_byte = in_word_i.data_byte;
    cls.new_connection = in_word_i.new_connection;
    cls.is_ws = (in_word_i.data_byte == hrhp_pkg::ChSpace) ||
                (in_word_i.data_byte == hrhp_pkg::ChTab);
    cls.is_digit = (in_word_i.data_byte >= hrhp_pkg::ChZero) &&
                   (in_word_i.data_byte <= hrhp_pkg::ChNine);
    cls.lower = (in_word_i.data_byte >= 8'h41 && in_word_i.data_byte <= 8'h5a) ?
                in_word_i.data_byte + 8'd32 : in_word_i.data_byte;
  end

  assign in_stall_o = (cnt_q == 3'd4);
  assign push = in_valid_i && !in_stall_o;
  assign pop = q_pop_i && q_valid_o;
  assign q_valid_o = (cnt_q != 3'd0);
  assign q_word_o = mem_q[rd_q];

  always_comb begin
    wr_d = push ? wr_q + 2'd1 : wr_q;
    rd_d = pop ? rd_q + 2'd1 : rd_q;
    cnt_d = cnt_q + {2'd0, push} - {2'd0, pop};
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= cls;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
      cnt_q <= '0;
    end else begin
      wr_q <= wr_d;
      rd_q <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  a_cnt_max: assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= 3'd4)
    else $error("queue count out of range");
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 3'd4) |-> !push) else $error("push into full queue");
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> (cnt_q != 3'd0)) else $error("pop from empty queue");
endmodule
`default_nettype wire

// ===== rtl/core/hrhp_back.sv =====
// Back end: per-byte request parsing state and verdict output register.
`default_nettype none
module hrhp_back (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 q_valid_i,
  output logic                      q_pop_o,
  input  wire hrhp_pkg::cls_word_t  q_word_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output hrhp_pkg::out_word_t       out_word_o
);
  localparam int unsigned CW = hrhp_pkg::CountW;

  hrhp_pkg::phase_e phase_q, phase_d;
  logic [3:0]  step_q, step_d;
  logic [4:0]  mi_q, mi_d;
  logic [7:0]  kc_q, kc_d;
  logic        crp_q, crp_d, post_q, post_d, ka_q, ka_d, vm_q, vm_d;
  logic [CW-1:0] bc_q, bc_d, ls_q, ls_d, us_q, us_d, uc_q, uc_d;
  logic [CW-1:0] hs_q, hs_d, hc_q, hc_d, bs_q, bs_d;
  logic [15:0] la_q, la_d, bl_q, bl_d;
  logic        sd_q, sd_d, pf_q, pf_d, lb_q, lb_d;

  logic        ov_q;
  hrhp_pkg::out_word_t ow_q;
  logic        emit;
  logic [1:0]  ev;
  logic [CW-1:0] eboff;
  logic        take;
  logic [7:0]  c, lc;
  logic        ws;
  logic [CW-1:0] here;
  logic        clr;

  assign out_valid_o = ov_q;
  assign out_word_o = ow_q;
  assign take = q_valid_i && (!ov_q || !out_stall_i);
  assign q_pop_o = take;
  assign c = q_word_i.data_byte;
  assign lc = q_word_i.lower;
  assign ws = q_word_i.is_ws;

  always_comb begin
    logic [CW-1:0] b0_bc;
    logic [7:0] alive;
    logic [4:0] m0;
    logic [7:0] k0;
    logic [19:0] prod;
    phase_d = phase_q; step_d = step_q; mi_d = mi_q; kc_d = kc_q; crp_d = crp_q;
    post_d = post_q; ka_d = ka_q; vm_d = vm_q; bc_d = bc_q; ls_d = ls_q;
    us_d = us_q; uc_d = uc_q; hs_d = hs_q; hc_d = hc_q; bs_d = bs_q;
    la_d = la_q; bl_d = bl_q; sd_d = sd_q; pf_d = pf_q; lb_d = lb_q;
    emit = 1'b0; ev = hrhp_pkg::VerdictOk; eboff = '0; clr = 1'b0;
    here = '0; alive = '0; prod = '0;
    b0_bc = '0; m0 = '0; k0 = '0;
    if (q_word_i.new_connection) begin
      phase_d = hrhp_pkg::PhaseReqLine; step_d = hrhp_pkg::StepMethod; mi_d = '0;
      kc_d = 8'd3;
      crp_d = 0; post_d = 0; ka_d = 0; vm_d = 0; bc_d = '0; ls_d = '0; us_d = '0;
      uc_d = '0; hs_d = '0; hc_d = '0; bs_d = '0; la_d = '0; bl_d = '0;
      sd_d = 0; pf_d = 0; lb_d = 0;
    end
    b0_bc = bc_d;
    if (b0_bc >= CW'(hrhp_pkg::BufferBytes)) begin
      emit = 1; ev = hrhp_pkg::VerdictOverflow;
    end else begin
      here = b0_bc;
      bc_d = b0_bc + 1'b1;
      if (phase_d == hrhp_pkg::PhaseBody) begin
        if (bl_d != 0) bl_d = bl_d - 1'b1;
        if (bl_d == 0) begin
          emit = 1; ev = hrhp_pkg::VerdictOk; eboff = bs_d;
        end
      end else if (crp_d) begin
        crp_d = 0;
        if (c != hrhp_pkg::ChLf) begin
          emit = 1; ev = hrhp_pkg::VerdictBad;
        end else if (phase_d == hrhp_pkg::PhaseReqLine) begin
          if (lb_d || step_d != hrhp_pkg::StepVersion || !vm_d || mi_d != 5'd8) begin
            emit = 1; ev = hrhp_pkg::VerdictBad;
          end else begin
            phase_d = hrhp_pkg::PhaseHeader; step_d = hrhp_pkg::StepName; mi_d = '0;
            kc_d = 8'd7; vm_d = 0; ls_d = here + 1'b1;
          end
        end else if (here == ls_d + 1'b1) begin
          if (la_d == 0) begin
            emit = 1; ev = hrhp_pkg::VerdictOk;
          end else begin
            phase_d = hrhp_pkg::PhaseBody; bl_d = la_d; bs_d = here + 1'b1;
          end
        end else begin
          if (kc_d == 8'd1 && step_d == hrhp_pkg::StepValue && vm_d && mi_d == 5'd10)
            ka_d = 1;
          step_d = hrhp_pkg::StepName; mi_d = '0; kc_d = 8'd7; vm_d = 0;
          ls_d = here + 1'b1;
        end
      end else if (c == hrhp_pkg::ChCr) begin
        crp_d = 1;
      end else if (c == hrhp_pkg::ChLf) begin
        emit = 1; ev = hrhp_pkg::VerdictBad;
      end else if (phase_d == hrhp_pkg::PhaseReqLine) begin
        case (step_d)
          hrhp_pkg::StepMethod: begin
            if (ws) begin
              if (kc_d[0] && mi_d == 5'd3) post_d = 0;
              else if (kc_d[1] && mi_d == 5'd4) post_d = 1;
              else lb_d = 1;
              step_d = hrhp_pkg::StepTargetGap;
            end else begin
              for (int i = 0; i < 2; i++)
                alive[i] = kc_d[i] &&
                  hrhp_pkg::char_hit(4'(hrhp_pkg::WGet + i), mi_d, lc);
              kc_d = alive;
              if (mi_d != 5'd31) mi_d = mi_d + 1'b1;
            end
          end
          hrhp_pkg::StepTargetGap, hrhp_pkg::StepTarget: begin
            if (step_d == hrhp_pkg::StepTarget && ws) begin
              if (!pf_d) lb_d = 1;
              step_d = hrhp_pkg::StepVersionGap;
            end else if (!(step_d == hrhp_pkg::StepTargetGap && ws)) begin
              if (step_d == hrhp_pkg::StepTargetGap) begin
                step_d = hrhp_pkg::StepTarget; mi_d = '0; kc_d = 8'd3; sd_d = 0; pf_d = 0;
              end
              if (pf_d) uc_d = uc_d + 1'b1;
              else if ((sd_d || mi_d == 0) && c == hrhp_pkg::ChSlash) begin
                pf_d = 1; us_d = here; uc_d = CW'(1);
              end else if (!sd_d) begin
                for (int i = 0; i < 2; i++)
                  alive[i] = kc_d[i] &&
                    hrhp_pkg::char_hit(4'(hrhp_pkg::WHttp + i), mi_d, lc);
                kc_d = alive;
                if (mi_d != 5'd31) mi_d = mi_d + 1'b1;
                if ((kc_d[0] && mi_d == 5'd7) || (kc_d[1] && mi_d == 5'd8)) sd_d = 1;
              end
            end
          end
          default: begin
            if (step_d == hrhp_pkg::StepVersionGap) begin
              if (!ws) begin
                step_d = hrhp_pkg::StepVersion; mi_d = '0; vm_d = 1;
              end
            end
            if (step_d == hrhp_pkg::StepVersion) begin
              if (!hrhp_pkg::char_hit(4'(hrhp_pkg::WVersion), mi_d, lc)) vm_d = 0;
              if (mi_d != 5'd31) mi_d = mi_d + 1'b1;
            end
          end
        endcase
      end else begin
        case (step_d)
          hrhp_pkg::StepName: begin
            for (int i = 0; i < 3; i++)
              alive[i] = kc_d[i] && hrhp_pkg::char_hit(4'(hrhp_pkg::WHdr + i), mi_d, lc);
            kc_d = alive;
            if (mi_d != 5'd31) mi_d = mi_d + 1'b1;
            if (kc_d == 0) step_d = hrhp_pkg::StepSkip;
            else begin
              k0 = kc_d; m0 = mi_d;
              for (int i = 0; i < 3; i++) begin
                if (k0[i] && hrhp_pkg::word_len(4'(hrhp_pkg::WHdr + i)) == m0) begin
                  kc_d = 8'(1 << i); step_d = hrhp_pkg::StepValueGap; mi_d = '0; vm_d = 1;
                  if (i == 1) la_d = '0;
                  if (i == 2) begin hs_d = here + 1'b1; hc_d = '0; end
                end
              end
            end
          end
          hrhp_pkg::StepValueGap, hrhp_pkg::StepValue: begin
            if (step_d == hrhp_pkg::StepValueGap && ws) begin
              if (kc_d == 8'd4) hs_d = here + 1'b1;
            end else begin
              step_d = hrhp_pkg::StepValue;
              if (kc_d == 8'd1) begin
                if (!hrhp_pkg::char_hit(4'(hrhp_pkg::WKeepAlive), mi_d, lc)) vm_d = 0;
                if (mi_d != 5'd31) mi_d = mi_d + 1'b1;
              end else if (kc_d == 8'd2) begin
                if (vm_d && q_word_i.is_digit) begin
                  prod = {4'd0, la_d} * 20'd10 + {12'd0, c - hrhp_pkg::ChZero};
                  la_d = (prod > 20'd65535) ? 16'hffff : prod[15:0];
                end else vm_d = 0;
              end else hc_d = hc_d + 1'b1;
            end
          end
          default: ;
        endcase
      end
    end
    if (emit) clr = 1;
    if (clr) begin
      phase_d = hrhp_pkg::PhaseReqLine; step_d = hrhp_pkg::StepMethod; mi_d = '0;
      kc_d = 8'd3;
      crp_d = 0; bc_d = '0; ls_d = '0; sd_d = 0; pf_d = 0; lb_d = 0; bl_d = '0;
      bs_d = '0;
    end
  end

  hrhp_pkg::out_word_t ow_d;
  always_comb begin
    logic ok;
    ok = (ev == hrhp_pkg::VerdictOk);
    ow_d.verdict = ev;
    ow_d.method = ok & post_d;
    ow_d.keep_alive = ok & ka_d;
    ow_d.content_len = ok ? la_d : '0;
    ow_d.url_offset = ok ? us_d[10:0] : '0;
    ow_d.url_length = ok ? uc_d[11:0] : '0;
    ow_d.url_is_root = ok && (uc_d == CW'(1));
    ow_d.host_offset = ok ? hs_d[10:0] : '0;
    ow_d.host_length = ok ? hc_d[11:0] : '0;
    ow_d.body_offset = ok ? eboff[10:0] : '0;
  end

  always_ff @(posedge clk_i) begin
    if (take && emit) ow_q <= ow_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 0;
      phase_q <= hrhp_pkg::PhaseReqLine; step_q <= hrhp_pkg::StepMethod; mi_q <= '0;
      kc_q <= 8'd3;
      crp_q <= 0; post_q <= 0; ka_q <= 0; vm_q <= 0; bc_q <= '0; ls_q <= '0;
      us_q <= '0; uc_q <= '0; hs_q <= '0; hc_q <= '0; bs_q <= '0; la_q <= '0;
      bl_q <= '0; sd_q <= 0; pf_q <= 0; lb_q <= 0;
    end else begin
      if (take) ov_q <= emit;
      else if (!out_stall_i) ov_q <= 0;
      if (take) begin
        phase_q <= phase_d; step_q <= step_d; mi_q <= mi_d; kc_q <= kc_d;
        crp_q <= crp_d; bc_q <= bc_d; ls_q <= ls_d; sd_q <= sd_d; pf_q <= pf_d;
        lb_q <= lb_d; bl_q <= bl_d; bs_q <= bs_d;
        if (emit) begin
          post_q <= 0; ka_q <= 0; vm_q <= 0; us_q <= '0; uc_q <= '0;
          hs_q <= '0; hc_q <= '0; la_q <= '0;
        end else begin
          post_q <= post_d; ka_q <= ka_d; vm_q <= vm_d; us_q <= us_d; uc_q <= uc_d;
          hs_q <= hs_d; hc_q <= hc_d; la_q <= la_d;
        end
      end
    end
  end

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && out_stall_i) |-> !take) else $error("result overwritten while stalled");
  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bc_q <= CW'(hrhp_pkg::BufferBytes)) else $error("byte count past buffer");
  a_body: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == hrhp_pkg::PhaseBody) |-> (bl_q != 0)) else $error("empty body phase");
endmodule
`default_nettype wire

// ===== rtl/core/http_request_header_parser_unit.sv =====
// Top level: HTTP/1.1 request header parser, front queue plus parsing back end.
// Takes one request byte per cycle and gives one verdict word per request
// (complete, bad request or buffer overflow). A four-entry queue separates
// byte intake from the parsing back end, so up to four more bytes are taken
// while a verdict waits in the stalled output register; once the queue is full
// the input stalls until the verdict leaves. Sustained rate is one byte per
// cycle while the output does not stall, as each byte's parse step is
// combinational. A byte is written into the queue, parsed from the queue head
// after any bytes already waiting there, and its verdict is registered in the
// output register. Both channels use valid/stall.
`default_nettype none
module http_request_header_parser_unit (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire hrhp_pkg::in_word_t  in_word_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output hrhp_pkg::out_word_t      out_word_o
);
  logic q_valid, q_pop;
  hrhp_pkg::cls_word_t q_word;

  // Classify bytes and buffer them ahead of the parser.
  hrhp_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_word_i,
    .q_valid_o(q_valid), .q_pop_i(q_pop), .q_word_o(q_word)
  );

  // Advance the parse state one byte per cycle unless a verdict is stalled at the output, and register verdicts.
  hrhp_back u_back (
    .clk_i, .rst_ni, .q_valid_i(q_valid), .q_pop_o(q_pop), .q_word_i(q_word),
    .out_valid_o, .out_stall_i, .out_word_o
  );
endmodule
`default_nettype wire
